[design/s20v_pkg.sv]
// Shared types, constants and small functions for the 16-bit-word Salsa20 stream XOR block.
// Depends on nothing; every design file imports it.
package s20v_pkg;

    localparam int WORD_W     = 16;
    localparam int WORDS      = 16;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = 5;
    localparam int QR_W       = 3;
    localparam int TAG_W      = 26;
    localparam int BLK_LSB    = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef logic [WORD_W-1:0] word_t;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_KEY0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE = 3'd4;

    // Low two bytes of each 4-byte group of the "expand 32-byte k" constant.
    localparam word_t SIGMA0 = 16'h7865;
    localparam word_t SIGMA1 = 16'h646e;
    localparam word_t SIGMA2 = 16'h2d32;
    localparam word_t SIGMA3 = 16'h6574;

    // Rotation amounts of the four quarter-round steps.
    localparam int ROT_B = 7;
    localparam int ROT_C = 9;
    localparam int ROT_D = 13;
    localparam int ROT_A = 18;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [31:0] byte_position;
        logic        last_byte;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_t;

    // Variable words of the initial block: key, nonce and block number.
    typedef struct packed {
        word_t [7:0] key_w;
        word_t [1:0] nonce_w;
        word_t       blk_w;
    } seed_t;

    // Keystream memory write beat from the block generator.
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        word_t            data;
    } ks_wr_t;

    // 32-bit rotation applied to a 16-bit value and cut back to 16 bits.
    function automatic word_t wrot(word_t v, int unsigned s);
        logic [31:0] a;
        logic [31:0] r;
        begin
            a = {16'b0, v};
            r = (a << s) | (a >> (32 - s));
            return r[WORD_W-1:0];
        end
    endfunction

    // Word indexes {a, b, c, d} of the eight quarter-rounds of a double round.
    function automatic logic [4*IDX_W-1:0] qr_words(logic [QR_W-1:0] q);
        logic [4*IDX_W-1:0] r;
        begin
            case (q)
                3'd0:    r = {4'd0,  4'd4,  4'd8,  4'd12};
                3'd1:    r = {4'd5,  4'd9,  4'd13, 4'd1};
                3'd2:    r = {4'd10, 4'd14, 4'd2,  4'd6};
                3'd3:    r = {4'd15, 4'd3,  4'd7,  4'd11};
                3'd4:    r = {4'd0,  4'd1,  4'd2,  4'd3};
                3'd5:    r = {4'd5,  4'd6,  4'd7,  4'd4};
                3'd6:    r = {4'd10, 4'd11, 4'd8,  4'd9};
                default: r = {4'd15, 4'd12, 4'd13, 4'd14};
            endcase
            return r;
        end
    endfunction

endpackage

[design/s20v_block_gen.sv]
// Keystream block generator: round-word memory, quarter-round sequencer and feed-forward.
// Depends on s20v_pkg; streams the finished block out as keystream memory writes.
module s20v_block_gen #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  s20v_pkg::seed_t seed,
    output logic            done,
    output s20v_pkg::ks_wr_t ks_wr
);
    import s20v_pkg::*;

    localparam int DR_W = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;
    localparam logic [DR_W-1:0] DR_LAST = DR_W'(DOUBLE_ROUNDS - 1);
    localparam logic [CNT_W-1:0] CNT_LAST_INIT = CNT_W'(WORDS - 1);
    localparam logic [CNT_W-1:0] CNT_FF_END    = CNT_W'(WORDS);
    localparam logic [QR_W-1:0]  QR_LAST       = QR_W'(7);

    localparam logic [1:0] G_IDLE = 2'd0;
    localparam logic [1:0] G_INIT = 2'd1;
    localparam logic [1:0] G_QR   = 2'd2;
    localparam logic [1:0] G_FF   = 2'd3;

    localparam logic [2:0] PH_RD_AB  = 3'd0;
    localparam logic [2:0] PH_RD_CD  = 3'd1;
    localparam logic [2:0] PH_CAP_CD = 3'd2;
    localparam logic [2:0] PH_B      = 3'd3;
    localparam logic [2:0] PH_C      = 3'd4;
    localparam logic [2:0] PH_D      = 3'd5;
    localparam logic [2:0] PH_A      = 3'd6;

    logic [1:0]       state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [2:0]       phase_reg;
    logic [QR_W-1:0]  q_reg;
    logic [DR_W-1:0]  dr_reg;

    word_t wa_reg, wb_reg, wc_reg, wd_reg;
    word_t rw_mem [WORDS];
    word_t rd0_reg, rd1_reg;

    logic [4*IDX_W-1:0] qi;
    logic [IDX_W-1:0]   a_idx, b_idx, c_idx, d_idx;
    logic [IDX_W-1:0]   rd_addr0, rd_addr1;
    logic [IDX_W-1:0]   ff_idx;
    logic               rw_we;
    logic [IDX_W-1:0]   rw_waddr;
    word_t              rw_wdata;
    word_t              step_x, step_y, step_z, step_sum, step_res;

    // Initial block word at a given index.
    function automatic word_t init_word(logic [IDX_W-1:0] idx, seed_t s);
        word_t r;
        begin
            case (idx)
                4'd0:    r = SIGMA0;
                4'd1:    r = s.key_w[0];
                4'd2:    r = s.key_w[1];
                4'd3:    r = s.key_w[2];
                4'd4:    r = s.key_w[3];
                4'd5:    r = SIGMA1;
                4'd6:    r = s.nonce_w[0];
                4'd7:    r = s.nonce_w[1];
                4'd8:    r = s.blk_w;
                4'd9:    r = '0;
                4'd10:   r = SIGMA2;
                4'd11:   r = s.key_w[4];
                4'd12:   r = s.key_w[5];
                4'd13:   r = s.key_w[6];
                4'd14:   r = s.key_w[7];
                default: r = SIGMA3;
            endcase
            return r;
        end
    endfunction

    assign qi    = qr_words(q_reg);
    assign a_idx = qi[4*IDX_W-1:3*IDX_W];
    assign b_idx = qi[3*IDX_W-1:2*IDX_W];
    assign c_idx = qi[2*IDX_W-1:IDX_W];
    assign d_idx = qi[IDX_W-1:0];

    // Read addresses: word pairs of the current quarter-round, or a sweep for feed-forward.
    always_comb
    begin
        rd_addr0 = a_idx;
        rd_addr1 = b_idx;
        if (state_reg == G_FF)
        begin
            rd_addr0 = cnt_reg[IDX_W-1:0];
        end
        else if (phase_reg == PH_RD_CD)
        begin
            rd_addr0 = c_idx;
            rd_addr1 = d_idx;
        end
    end

    // One add, rotate and XOR step of the quarter-round, chosen by phase.
    always_comb
    begin
        case (phase_reg)
            PH_B:
            begin
                step_x = wb_reg;
                step_y = wa_reg;
                step_z = wd_reg;
            end
            PH_C:
            begin
                step_x = wc_reg;
                step_y = wb_reg;
                step_z = wa_reg;
            end
            PH_D:
            begin
                step_x = wd_reg;
                step_y = wc_reg;
                step_z = wb_reg;
            end
            default:
            begin
                step_x = wa_reg;
                step_y = wd_reg;
                step_z = wc_reg;
            end
        endcase
        step_sum = step_y + step_z;
        case (phase_reg)
            PH_B:    step_res = step_x ^ wrot(step_sum, ROT_B);
            PH_C:    step_res = step_x ^ wrot(step_sum, ROT_C);
            PH_D:    step_res = step_x ^ wrot(step_sum, ROT_D);
            default: step_res = step_x ^ wrot(step_sum, ROT_A);
        endcase
    end

    // Round memory write port: initial words, then each quarter-round result.
    always_comb
    begin
        rw_we    = 1'b0;
        rw_waddr = cnt_reg[IDX_W-1:0];
        rw_wdata = init_word(cnt_reg[IDX_W-1:0], seed);
        if (state_reg == G_INIT)
        begin
            rw_we = 1'b1;
        end
        else if (state_reg == G_QR)
        begin
            rw_wdata = step_res;
            case (phase_reg)
                PH_B:
                begin
                    rw_we    = 1'b1;
                    rw_waddr = b_idx;
                end
                PH_C:
                begin
                    rw_we    = 1'b1;
                    rw_waddr = c_idx;
                end
                PH_D:
                begin
                    rw_we    = 1'b1;
                    rw_waddr = d_idx;
                end
                PH_A:
                begin
                    rw_we    = 1'b1;
                    rw_waddr = a_idx;
                end
                default:
                begin
                    rw_we = 1'b0;
                end
            endcase
        end
    end

    // Feed-forward: the word read in the previous cycle plus its initial value.
    assign ff_idx      = cnt_reg[IDX_W-1:0] - IDX_W'(1);
    assign ks_wr.we    = (state_reg == G_FF) && (cnt_reg != '0);
    assign ks_wr.addr  = ff_idx;
    assign ks_wr.data  = rd0_reg + init_word(ff_idx, seed);
    assign done        = (state_reg == G_FF) && (cnt_reg == CNT_FF_END);

    // Round memory and working words.
    always_ff @(posedge clk)
    begin
        if (rw_we)
        begin
            rw_mem[rw_waddr] <= rw_wdata;
        end
        rd0_reg <= rw_mem[rd_addr0];
        rd1_reg <= rw_mem[rd_addr1];
        if (state_reg == G_QR)
        begin
            case (phase_reg)
                PH_RD_CD:
                begin
                    wa_reg <= rd0_reg;
                    wb_reg <= rd1_reg;
                end
                PH_CAP_CD:
                begin
                    wc_reg <= rd0_reg;
                    wd_reg <= rd1_reg;
                end
                PH_B:    wb_reg <= step_res;
                PH_C:    wc_reg <= step_res;
                PH_D:    wd_reg <= step_res;
                default: wa_reg <= wa_reg;
            endcase
        end
    end

    // Sequencer: initial fill, quarter-rounds of each double round, feed-forward sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= G_IDLE;
            cnt_reg   <= '0;
            phase_reg <= PH_RD_AB;
            q_reg     <= '0;
            dr_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                G_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= G_INIT;
                        cnt_reg   <= '0;
                    end
                end
                G_INIT:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_LAST_INIT)
                    begin
                        state_reg <= G_QR;
                        phase_reg <= PH_RD_AB;
                        q_reg     <= '0;
                        dr_reg    <= '0;
                    end
                end
                G_QR:
                begin
                    if (phase_reg == PH_A)
                    begin
                        phase_reg <= PH_RD_AB;
                        q_reg     <= q_reg + QR_W'(1);
                        if (q_reg == QR_LAST)
                        begin
                            dr_reg <= dr_reg + DR_W'(1);
                            if (dr_reg == DR_LAST)
                            begin
                                state_reg <= G_FF;
                                cnt_reg   <= '0;
                            end
                        end
                    end
                    else
                    begin
                        phase_reg <= phase_reg + 3'd1;
                    end
                end
                default:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_FF_END)
                    begin
                        state_reg <= G_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

[design/salsa20_16bit_variant_stream_xor.sv]
// Top level of the 16-bit-word Salsa20 stream XOR: configuration, block cache and byte lookup.
// Depends on s20v_pkg and s20v_block_gen.
//
//   Channel  Direction  Handshake             Beat payload
//   in       input      in_valid / in_stall   in_data  (data byte, position, last mark)
//   out      output     out_valid / out_stall out_data (XORed byte, last mark)
//   cfg      input      cfg_we                cfg_index, cfg_data
//
// A byte whose block is cached passes the idle and lookup states. A byte that needs a new block
// waits while the generator fills the round memory, runs each quarter-round through the
// two-read, one-write round memory and then runs the feed-forward.
// Reset clears the configuration and the cache tag; no block is cached afterwards.
// A stalled output holds its beat while the next input beat may already be taken.
module salsa20_16bit_variant_stream_xor #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  s20v_pkg::in_t                       in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output s20v_pkg::out_t                      out_data,
    input  logic                                cfg_we,
    input  logic [s20v_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [s20v_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import s20v_pkg::*;

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_LOOK = 2'd1;
    localparam logic [1:0] T_GEN  = 2'd2;
    localparam logic [1:0] T_KSRD = 2'd3;

    logic [1:0]       state_reg;
    in_t              item_reg;
    out_t             out_reg;
    logic             out_valid_reg;
    logic             cache_valid_reg;
    logic [TAG_W-1:0] tag_reg;
    word_t [7:0]      key_w_reg;
    word_t [1:0]      nonce_w_reg;

    word_t            ks_mem [WORDS];
    word_t            ks_rd_reg;
    logic             ks_re;
    logic [IDX_W-1:0] ks_raddr;

    seed_t            seed;
    logic             gen_start;
    logic             gen_done;
    ks_wr_t           ks_wr;
    logic             hit;
    logic             out_free;
    logic             out_load;
    logic [7:0]       ks_byte;

    // Keystream byte from the serialized word: low byte, high byte, then two zero bytes.
    always_comb
    begin
        case (item_reg.byte_position[1:0])
            2'd0:    ks_byte = ks_rd_reg[7:0];
            2'd1:    ks_byte = ks_rd_reg[15:8];
            default: ks_byte = 8'd0;
        endcase
    end

    assign hit       = cache_valid_reg
                       && (tag_reg == item_reg.byte_position[BLK_LSB +: TAG_W]);
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_load  = (state_reg == T_LOOK) && hit && out_free;
    assign gen_start = (state_reg == T_LOOK) && !hit;
    assign in_stall  = (state_reg != T_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // The keystream word is read as the beat arrives, and again once a new block is ready.
    assign ks_re    = ((state_reg == T_IDLE) && in_valid) || (state_reg == T_KSRD);
    assign ks_raddr = (state_reg == T_IDLE) ? in_data.byte_position[5:2]
                                            : item_reg.byte_position[5:2];

    assign seed.key_w   = key_w_reg;
    assign seed.nonce_w = nonce_w_reg;
    assign seed.blk_w   = item_reg.byte_position[BLK_LSB +: WORD_W];

    s20v_block_gen #(
        .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
    ) u_block_gen (
        .clk   (clk),
        .rst_n (rst_n),
        .start (gen_start),
        .seed  (seed),
        .done  (gen_done),
        .ks_wr (ks_wr)
    );

    // Keystream memory of the cached block.
    always_ff @(posedge clk)
    begin
        if (ks_wr.we)
        begin
            ks_mem[ks_wr.addr] <= ks_wr.data;
        end
        if (ks_re)
        begin
            ks_rd_reg <= ks_mem[ks_raddr];
        end
    end

    // Payload registers of the held input beat and the output beat.
    always_ff @(posedge clk)
    begin
        if ((state_reg == T_IDLE) && in_valid)
        begin
            item_reg <= in_data;
        end
        if (out_load)
        begin
            out_reg.out_byte <= item_reg.data_byte ^ ks_byte;
            out_reg.out_last <= item_reg.last_byte;
        end
    end

    // Control: beat sequencing, output valid, cache tag and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= T_IDLE;
            out_valid_reg   <= 1'b0;
            cache_valid_reg <= 1'b0;
            tag_reg         <= '0;
            key_w_reg       <= '0;
            nonce_w_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                T_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= T_LOOK;
                    end
                end
                T_LOOK:
                begin
                    if (!hit)
                    begin
                        state_reg <= T_GEN;
                    end
                    else if (out_free)
                    begin
                        state_reg <= T_IDLE;
                    end
                end
                T_GEN:
                begin
                    if (gen_done)
                    begin
                        cache_valid_reg <= 1'b1;
                        tag_reg         <= item_reg.byte_position[BLK_LSB +: TAG_W];
                        state_reg       <= T_KSRD;
                    end
                end
                default:
                begin
                    state_reg <= T_LOOK;
                end
            endcase

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            // Any write to a defined register drops the cached block.
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_KEY0:
                    begin
                        key_w_reg[0]    <= cfg_data[15:0];
                        key_w_reg[1]    <= cfg_data[47:32];
                        cache_valid_reg <= 1'b0;
                    end
                    CFG_KEY1:
                    begin
                        key_w_reg[2]    <= cfg_data[15:0];
                        key_w_reg[3]    <= cfg_data[47:32];
                        cache_valid_reg <= 1'b0;
                    end
                    CFG_KEY2:
                    begin
                        key_w_reg[4]    <= cfg_data[15:0];
                        key_w_reg[5]    <= cfg_data[47:32];
                        cache_valid_reg <= 1'b0;
                    end
                    CFG_KEY3:
                    begin
                        key_w_reg[6]    <= cfg_data[15:0];
                        key_w_reg[7]    <= cfg_data[47:32];
                        cache_valid_reg <= 1'b0;
                    end
                    CFG_NONCE:
                    begin
                        nonce_w_reg[0]  <= cfg_data[15:0];
                        nonce_w_reg[1]  <= cfg_data[47:32];
                        cache_valid_reg <= 1'b0;
                    end
                    default:
                    begin
                        cache_valid_reg <= cache_valid_reg;
                    end
                endcase
            end
        end
    end

endmodule
